// ===== rtl/mips1_integer_execute_unit_macros.svh =====
// Assertion helpers for the execute unit.
`ifndef MIPS1_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define MIPS1_INTEGER_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MIE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MIE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MIE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MIE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/mie_pkg.sv =====
`default_nettype none
package mie_pkg;
  localparam int DMEM_AW    = 12;
  localparam int DMEM_WORDS = 1 << DMEM_AW;

  typedef enum logic [5:0] {
    F_LB = 6'd0, F_LBU = 6'd1, F_LH = 6'd2, F_LHU = 6'd3, F_LW = 6'd4, F_LL = 6'd5,
    F_LWL = 6'd6, F_LWR = 6'd7, F_SB = 6'd8, F_SH = 6'd9, F_SW = 6'd10, F_SC = 6'd11,
    F_SWL = 6'd12, F_SWR = 6'd13, F_ADDI = 6'd14, F_ADDIU = 6'd15, F_SLTI = 6'd16,
    F_SLTIU = 6'd17, F_ANDI = 6'd18, F_ORI = 6'd19, F_XORI = 6'd20, F_LUI = 6'd21,
    F_ADD = 6'd22, F_ADDU = 6'd23, F_SUB = 6'd24, F_SUBU = 6'd25, F_SLT = 6'd26,
    F_SLTU = 6'd27, F_AND = 6'd28, F_OR = 6'd29, F_XOR = 6'd30, F_NOR = 6'd31,
    F_NOP = 6'd32, F_SLL = 6'd33, F_SRL = 6'd34, F_SRA = 6'd35, F_SLLV = 6'd36,
    F_SRLV = 6'd37, F_SRAV = 6'd38, F_MULT = 6'd39, F_MULTU = 6'd40, F_DIV = 6'd41,
    F_DIVU = 6'd42, F_MFHI = 6'd43, F_MTHI = 6'd44, F_MFLO = 6'd45, F_MTLO = 6'd46,
    F_J = 6'd47, F_JAL = 6'd48, F_JR = 6'd49, F_JALR = 6'd50, F_BEQ = 6'd51,
    F_BNE = 6'd52, F_BLEZ = 6'd53, F_BGTZ = 6'd54, F_BLTZ = 6'd55, F_BGEZ = 6'd56,
    F_BLTZAL = 6'd57, F_BGEZAL = 6'd58, F_SYSCALL = 6'd59, F_BREAK = 6'd60
  } func_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVF     = 3'd1;
  localparam logic [2:0] ST_SYSCALL = 3'd2;
  localparam logic [2:0] ST_BREAK   = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [5:0]  func;
    logic [4:0]  dst_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [25:0] jump_index;
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/mie_instr_if.sv =====
`default_nettype none
interface mie_instr_if;
  logic               valid;
  logic               ready;
  logic [5:0]         func;
  logic [4:0]         src_reg;
  logic [4:0]         tgt_reg;
  logic [4:0]         dst_reg;
  logic [4:0]         shift_amount;
  logic signed [15:0] immediate;
  logic [25:0]        jump_index;
  modport source(output valid, func, src_reg, tgt_reg, dst_reg, shift_amount, immediate,
                 jump_index, input ready);
  modport sink(input valid, func, src_reg, tgt_reg, dst_reg, shift_amount, immediate,
               jump_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/mie_result_if.sv =====
`default_nettype none
interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] exec_pc;
  logic [31:0] fetch_pc;
  logic        wrote_reg;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic [2:0]  status;
  modport source(output valid, exec_pc, fetch_pc, wrote_reg, written_index, written_value,
                 status, input ready);
  modport sink(input valid, exec_pc, fetch_pc, wrote_reg, written_index, written_value,
               status, output ready);
endinterface
`default_nettype wire

// ===== rtl/mie_regfile.sv =====
`default_nettype none
module mie_regfile
  import mie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire logic [4:0]  rd_addr_a,
  input  wire logic [4:0]  rd_addr_b,
  output logic      [31:0] rd_data_a,
  output logic      [31:0] rd_data_b,
  input  wire rf_wr_t      wr
);
  logic [31:0] mem [32];
  logic [31:0] written;
  logic [31:0] raw_a, raw_b;
  logic        ok_a, ok_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      raw_a <= mem[rd_addr_a];
      raw_b <= mem[rd_addr_b];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ok_a    <= 1'b0;
      ok_b    <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        ok_a <= written[rd_addr_a];
        ok_b <= written[rd_addr_b];
      end
    end
  end

  assign rd_data_a = ok_a ? raw_a : '0;
  assign rd_data_b = ok_b ? raw_b : '0;
endmodule
`default_nettype wire

// ===== rtl/mie_dmem.sv =====
`default_nettype none
module mie_dmem
  import mie_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [DMEM_AW-1:0] rd_addr,
  output logic      [31:0]        rd_data,
  input  wire logic               we,
  input  wire logic [DMEM_AW-1:0] wr_addr,
  input  wire logic [31:0]        wr_data
);
  logic [31:0] mem [DMEM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mie_divider.sv =====
`default_nettype none
module mie_divider
  import mie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_signed,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic      [31:0] quotient,
  output logic      [31:0] remainder
);
  logic        busy;
  logic [4:0]  count;
  logic [31:0] rem, quo, mb, a_keep;
  logic        neg_q, neg_r, by_zero;
  logic [32:0] trial;

  // One quotient bit per cycle, restoring.
  assign trial = {rem, quo[31]} - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q   <= is_signed & (dividend[31] ^ divisor[31]);
      neg_r   <= is_signed & dividend[31];
      by_zero <= (divisor == '0);
      a_keep  <= dividend;
      quo     <= (is_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
      mb      <= (is_signed && divisor[31]) ? (32'd0 - divisor) : divisor;
      rem     <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = by_zero ? '1 : (neg_q ? (32'd0 - quo) : quo);
  assign remainder = by_zero ? a_keep : (neg_r ? (32'd0 - rem) : rem);
endmodule
`default_nettype wire

// ===== rtl/mips1_integer_execute_unit.sv =====
// Channel  | Dir | Word
// ---------+-----+----------------------------------------------------------
// instr    | in  | func, src_reg, tgt_reg, dst_reg, shift_amount, immediate,
//          |     | jump_index
// result   | out | exec_pc, fetch_pc, wrote_reg, written_index, written_value,
//          |     | status
// cfg      | in  | cfg_wr_en / cfg_wr_data: start address, reloads both PCs
//
// An instruction passes through register file read, data memory read, then
// write back and result. div and divu also wait in S_DIV on the one-bit-per-
// cycle divider. After reset a clearing pass zeroes all DMEM_WORDS (4096)
// words of the data memory, one word a cycle, before the first word is taken.
// A stalled result holds the write-back stage; a new word is taken while the
// previous result still waits in the output register.
`default_nettype none
`include "mips1_integer_execute_unit_macros.svh"
module mips1_integer_execute_unit
  import mie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  mie_instr_if.sink        instr,
  mie_result_if.source     result
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_EX, S_DIV, S_WB} state_t;

  state_t state;
  logic [DMEM_AW-1:0] clr_idx;
  item_t       item;
  logic [4:0]  u_rt;
  logic [31:0] current_pc, following_pc, hi_reg, lo_reg;
  logic        link_valid, halted;
  logic [31:0] link_address, link_old_value;
  logic [31:0] ea;
  logic [63:0] prod;

  logic [31:0] a, b, m, q_div, r_div;
  logic        div_done;
  rf_wr_t      rf_wr;
  logic        accept, commit;

  logic [31:0] simm, zimm, ea_c, base, br_tgt;
  logic [DMEM_AW-1:0] rd_slot;
  logic [1:0]  k;

  // Write-back decisions.
  logic        wr;
  logic [4:0]  widx;
  logic [31:0] val, fpc_next, hi_next, lo_next, mwdata, mmask, msrc, h_mul;
  logic [2:0]  st;
  logic        mem_we, link_ok, hilo_we, link_set;
  logic        dm_we;
  logic [DMEM_AW-1:0] dm_waddr;
  logic [31:0] dm_wdata;

  assign accept      = instr.valid && instr.ready;
  assign instr.ready = (state == S_IDLE);
  assign commit      = (state == S_WB) && (!result.valid || result.ready);

  mie_regfile u_rf (
    .clk, .rst,
    .rd_en(accept), .rd_addr_a(instr.src_reg), .rd_addr_b(instr.tgt_reg),
    .rd_data_a(a), .rd_data_b(b), .wr(rf_wr)
  );

  // Effective address and memory slot, in the execute cycle.
  assign simm = {{16{item.immediate[15]}}, item.immediate};
  assign zimm = {16'd0, item.immediate};
  assign ea_c = a + simm;
  assign rd_slot = (item.func == F_SC) ? link_address[DMEM_AW+1:2] : ea_c[DMEM_AW+1:2];

  mie_dmem u_dm (
    .clk, .rd_en(state == S_EX), .rd_addr(rd_slot), .rd_data(m),
    .we(dm_we), .wr_addr(dm_waddr), .wr_data(dm_wdata)
  );

  mie_divider u_div (
    .clk, .rst,
    .start(state == S_EX && (item.func == F_DIV || item.func == F_DIVU)),
    .is_signed(item.func == F_DIV), .dividend(a), .divisor(b),
    .done(div_done), .quotient(q_div), .remainder(r_div)
  );

  // Clearing pass owns the write port until it finishes.
  assign dm_we    = (state == S_CLR) || (commit && mem_we);
  assign dm_waddr = (state == S_CLR) ? clr_idx : ea[DMEM_AW+1:2];
  assign dm_wdata = (state == S_CLR) ? '0 : ((m & ~mmask) | (mwdata & mmask));

  assign rf_wr.en   = commit && wr;
  assign rf_wr.idx  = widx;
  assign rf_wr.data = val;

  assign k      = ea[1:0];
  assign base   = following_pc;
  assign br_tgt = base + {simm[29:0], 2'b00};
  assign h_mul  = prod[63:32] - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);

  always_comb begin
    wr       = 1'b0;
    widx     = item.dst_reg;
    val      = '0;
    st       = ST_OK;
    fpc_next = base + 32'd4;
    hilo_we  = 1'b0;
    hi_next  = hi_reg;
    lo_next  = lo_reg;
    mem_we   = 1'b0;
    mwdata   = '0;
    mmask    = '0;
    msrc     = '0;
    link_ok  = link_valid && (m == link_old_value);
    link_set = 1'b0;
    case (item.func)
      F_LB, F_LBU: begin
        msrc = m >> {3'd3 - {1'b0, k}, 3'd0};
        val  = (item.func == F_LB) ? {{24{msrc[7]}}, msrc[7:0]} : {24'd0, msrc[7:0]};
        wr   = 1'b1;
      end
      F_LH, F_LHU: begin
        msrc = ea[1] ? m : (m >> 16);
        val  = (item.func == F_LH) ? {{16{msrc[15]}}, msrc[15:0]} : {16'd0, msrc[15:0]};
        wr   = 1'b1;
      end
      F_LW: begin
        val = m;
        wr  = 1'b1;
      end
      F_LL: begin
        val      = m;
        wr       = 1'b1;
        link_set = 1'b1;
      end
      F_LWL: begin
        case (k)
          2'd0:    val = m;
          2'd1:    val = {m[23:0], b[7:0]};
          2'd2:    val = {m[15:0], b[15:0]};
          default: val = {m[7:0], b[23:0]};
        endcase
        wr = 1'b1;
      end
      F_LWR: begin
        case (k)
          2'd3:    val = m;
          2'd2:    val = {b[31:24], m[31:8]};
          2'd1:    val = {b[31:16], m[31:16]};
          default: val = {b[31:8], m[31:24]};
        endcase
        wr = 1'b1;
      end
      F_SB: begin
        mem_we = 1'b1;
        mwdata = {24'd0, b[7:0]} << {3'd3 - {1'b0, k}, 3'd0};
        mmask  = 32'h0000_00FF << {3'd3 - {1'b0, k}, 3'd0};
      end
      F_SH: begin
        mem_we = 1'b1;
        mwdata = ea[1] ? {16'd0, b[15:0]} : {b[15:0], 16'd0};
        mmask  = ea[1] ? 32'h0000_FFFF : 32'hFFFF_0000;
      end
      F_SW: begin
        mem_we = 1'b1;
        mwdata = b;
        mmask  = '1;
      end
      F_SC: begin
        mem_we = link_ok;
        mwdata = b;
        mmask  = '1;
        val    = {31'd0, link_ok};
        wr     = 1'b1;
      end
      F_SWL: begin
        mem_we = 1'b1;
        mwdata = b >> {k, 3'd0};
        mmask  = 32'hFFFF_FFFF >> {k, 3'd0};
      end
      F_SWR: begin
        mem_we = 1'b1;
        mwdata = b << {2'd3 - k, 3'd0};
        mmask  = 32'hFFFF_FFFF << {2'd3 - k, 3'd0};
      end
      F_ADDI: begin
        val = a + simm;
        if ((a[31] == simm[31]) && (val[31] != a[31])) st = ST_OVF;
        else wr = 1'b1;
      end
      F_ADDIU: begin val = a + simm; wr = 1'b1; end
      F_SLTI:  begin val = {31'd0, $signed(a) < $signed(simm)}; wr = 1'b1; end
      F_SLTIU: begin val = {31'd0, a < simm}; wr = 1'b1; end
      F_ANDI:  begin val = a & zimm; wr = 1'b1; end
      F_ORI:   begin val = a | zimm; wr = 1'b1; end
      F_XORI:  begin val = a ^ zimm; wr = 1'b1; end
      F_LUI:   begin val = {item.immediate, 16'd0}; wr = 1'b1; end
      F_ADD: begin
        val = a + b;
        if ((a[31] == b[31]) && (val[31] != a[31])) st = ST_OVF;
        else wr = 1'b1;
      end
      F_ADDU: begin val = a + b; wr = 1'b1; end
      F_SUB: begin
        val = a - b;
        if ((a[31] != b[31]) && (val[31] != a[31])) st = ST_OVF;
        else wr = 1'b1;
      end
      F_SUBU: begin val = a - b; wr = 1'b1; end
      F_SLT:  begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
      F_SLTU: begin val = {31'd0, a < b}; wr = 1'b1; end
      F_AND:  begin val = a & b; wr = 1'b1; end
      F_OR:   begin val = a | b; wr = 1'b1; end
      F_XOR:  begin val = a ^ b; wr = 1'b1; end
      F_NOR:  begin val = ~(a | b); wr = 1'b1; end
      F_SLL:  begin val = b << item.shift_amount; wr = 1'b1; end
      F_SRL:  begin val = b >> item.shift_amount; wr = 1'b1; end
      F_SRA:  begin val = $unsigned($signed(b) >>> item.shift_amount); wr = 1'b1; end
      F_SLLV: begin val = b << a[4:0]; wr = 1'b1; end
      F_SRLV: begin val = b >> a[4:0]; wr = 1'b1; end
      F_SRAV: begin val = $unsigned($signed(b) >>> a[4:0]); wr = 1'b1; end
      F_MULT, F_MULTU: begin
        hilo_we = 1'b1;
        lo_next = prod[31:0];
        hi_next = (item.func == F_MULT) ? h_mul : prod[63:32];
      end
      F_DIV, F_DIVU: begin
        hilo_we = 1'b1;
        lo_next = q_div;
        hi_next = r_div;
      end
      F_MFHI: begin val = hi_reg; wr = 1'b1; end
      F_MTHI: begin hilo_we = 1'b1; hi_next = a; end
      F_MFLO: begin val = lo_reg; wr = 1'b1; end
      F_MTLO: begin hilo_we = 1'b1; lo_next = a; end
      F_J: fpc_next = {base[31:28], item.jump_index, 2'b00};
      F_JAL: begin
        fpc_next = {base[31:28], item.jump_index, 2'b00};
        val = base + 32'd4; wr = 1'b1; widx = 5'd31;
      end
      F_JR: fpc_next = a;
      F_JALR: begin
        fpc_next = a;
        val = base + 32'd4; wr = 1'b1;
        widx = (item.dst_reg == 5'd0) ? 5'd31 : item.dst_reg;
      end
      F_BEQ:  if (a == b) fpc_next = br_tgt;
      F_BNE:  if (a != b) fpc_next = br_tgt;
      F_BLEZ: if (a == '0 || a[31]) fpc_next = br_tgt;
      F_BGTZ: if (!a[31] && a != '0) fpc_next = br_tgt;
      F_BLTZ: if (a[31]) fpc_next = br_tgt;
      F_BGEZ: if (!a[31]) fpc_next = br_tgt;
      F_BLTZAL: begin
        if (a[31]) fpc_next = br_tgt;
        val = base + 32'd4; wr = 1'b1; widx = 5'd31;
      end
      F_BGEZAL: begin
        if (!a[31]) fpc_next = br_tgt;
        val = base + 32'd4; wr = 1'b1; widx = 5'd31;
      end
      F_SYSCALL: st = ST_SYSCALL;
      F_BREAK:   st = ST_BREAK;
      default: ;
    endcase
    // Loads, sc and immediates target rt.
    if (item.func <= F_LUI && item.func != F_SB && item.func != F_SH &&
        item.func != F_SW && item.func != F_SWL && item.func != F_SWR) begin
      widx = u_rt;
    end
    // Drop writes to r0; a halted block changes nothing.
    if (!wr || widx == 5'd0 || halted) begin
      wr = 1'b0; widx = '0; val = '0;
    end
    if (halted) begin
      st = ST_HALTED; mem_we = 1'b0; hilo_we = 1'b0; link_set = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_reg         <= '0;
      lo_reg         <= '0;
      link_address   <= '0;
      link_old_value <= '0;
    end else begin
      if (commit && hilo_we) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
      end
      if (commit && link_set) begin
        link_address   <= ea;
        link_old_value <= m;
      end
    end
    if (accept) begin
      item.func         <= instr.func;
      item.dst_reg      <= instr.dst_reg;
      item.shift_amount <= instr.shift_amount;
      item.immediate    <= instr.immediate;
      item.jump_index   <= instr.jump_index;
      u_rt              <= instr.tgt_reg;
    end
    if (state == S_EX) begin
      ea   <= ea_c;
      prod <= {32'd0, a} * {32'd0, b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      current_pc    <= '0;
      following_pc  <= 32'd4;
      link_valid    <= 1'b0;
      halted        <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      // Drop the taken word unless a new one lands in the same cycle.
      if (result.valid && result.ready && !commit) begin
        result.valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        current_pc   <= cfg_wr_data;
        following_pc <= cfg_wr_data + 32'd4;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= S_IDLE;
        end
        S_IDLE: if (accept) state <= S_EX;
        S_EX: begin
          if (item.func == F_DIV || item.func == F_DIVU) state <= S_DIV;
          else state <= S_WB;
        end
        S_DIV: if (div_done) state <= S_WB;
        S_WB: begin
          if (commit) begin
            state                <= S_IDLE;
            result.valid         <= 1'b1;
            result.status        <= st;
            result.wrote_reg     <= wr;
            result.written_index <= widx;
            result.written_value <= val;
            if (halted) begin
              result.exec_pc  <= current_pc;
              result.fetch_pc <= current_pc;
            end else begin
              result.exec_pc  <= current_pc;
              result.fetch_pc <= following_pc;
              current_pc      <= following_pc;
              following_pc    <= fpc_next;
              if (st != ST_OK) halted <= 1'b1;
              if (item.func == F_SC && !link_ok) link_valid <= 1'b0;
              if (link_set) link_valid <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MIE_ASSERT_IMP(a_no_r0_write, clk, rst, rf_wr.en, rf_wr.idx != 5'd0)
  `MIE_ASSERT_IMP(a_halt_quiet, clk, rst, result.valid && result.status == ST_HALTED,
                  !result.wrote_reg && result.exec_pc == result.fetch_pc)
  `MIE_ASSERT_IMP(a_trap_no_write, clk, rst, result.valid && result.status == ST_OVF,
                  !result.wrote_reg)
  `MIE_ASSERT_NXT(a_one_at_a_time, clk, rst, accept, !instr.ready)
endmodule
`default_nettype wire

// ===== sim/tb_mips1_integer_execute_unit.sv =====
`timescale 1ns / 1ps
module tb_mips1_integer_execute_unit;
  import mie_pkg::*;

  // A func code with no instruction behind it; acts as nop.
  localparam logic [5:0] F_UNUSED = 6'd61;

  typedef struct {
    logic [5:0]  func;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [25:0] jump_index;
  } instr_word_t;

  typedef struct {
    logic [31:0] exec_pc;
    logic [31:0] fetch_pc;
    logic        wrote_reg;
    logic [4:0]  written_index;
    logic [31:0] written_value;
    logic [2:0]  status;
  } retire_t;

  // Queue of retire records still owed by the block, oldest first.
  class retire_ledger;
    retire_t owed[$];
    int      errors;

    function void note_retire(retire_t r);
      owed.push_back(r);
    endfunction

    function void check_retire(retire_t got);
      retire_t w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result exec_pc=%h", $time, got.exec_pc);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.exec_pc !== w.exec_pc) begin
        $display("%0t: exec_pc exp %h got %h", $time, w.exec_pc, got.exec_pc);
        errors++;
      end
      if (got.fetch_pc !== w.fetch_pc) begin
        $display("%0t: fetch_pc exp %h got %h", $time, w.fetch_pc, got.fetch_pc);
        errors++;
      end
      if (got.wrote_reg !== w.wrote_reg) begin
        $display("%0t: wrote_reg exp %b got %b", $time, w.wrote_reg, got.wrote_reg);
        errors++;
      end
      if (got.written_index !== w.written_index) begin
        $display("%0t: written_index exp %0d got %0d", $time, w.written_index,
                 got.written_index);
        errors++;
      end
      if (got.written_value !== w.written_value) begin
        $display("%0t: written_value exp %h got %h", $time, w.written_value,
                 got.written_value);
        errors++;
      end
      if (got.status !== w.status) begin
        $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  mie_instr_if  instr();
  mie_result_if result();

  mips1_integer_execute_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .instr       (instr.sink),
    .result      (result.source)
  );

  always #6 clk = ~clk;

  retire_ledger ledger = new();

  // Shadow architectural state of the execute unit.
  logic [31:0] sh_regs [32];
  logic [31:0] sh_mem [DMEM_WORDS];
  logic [31:0] sh_hi, sh_lo, sh_cur_pc, sh_nxt_pc;
  logic        sh_link_ok, sh_halted;
  logic [31:0] sh_link_addr, sh_link_old;

  // Hold all idling off while set: gives stretches at full rate.
  bit no_gaps = 0;

  function automatic logic [31:0] word_at(logic [31:0] addr);
    return sh_mem[addr[DMEM_AW+1:2]];
  endfunction

  function automatic void merge_word(logic [31:0] addr, logic [31:0] v, logic [31:0] m);
    sh_mem[addr[DMEM_AW+1:2]] = (sh_mem[addr[DMEM_AW+1:2]] & ~m) | (v & m);
  endfunction

  // True when add, addi or sub would take the overflow trap now.
  function automatic bit would_trap(instr_word_t it);
    logic [31:0] a, b, s, r;
    a = sh_regs[it.src_reg];
    b = sh_regs[it.tgt_reg];
    s = {{16{it.immediate[15]}}, it.immediate};
    case (it.func)
      F_ADDI: begin r = a + s; return !(a[31] ^ s[31]) && (r[31] ^ a[31]); end
      F_ADD:  begin r = a + b; return !(a[31] ^ b[31]) && (r[31] ^ a[31]); end
      F_SUB:  begin r = a - b; return (a[31] ^ b[31]) && (r[31] ^ a[31]); end
      default: return 1'b0;
    endcase
  endfunction

  // Execute one instruction against the shadow state; return what retires.
  function automatic retire_t execute_instr(instr_word_t it);
    retire_t     r;
    logic [31:0] a, b, simm, zimm, base, ea, m, v, q, rm, ma, mb;
    logic [63:0] p;
    logic [5:0]  off;
    logic [4:0]  widx;
    logic [2:0]  st;
    bit          wr, na, nb;
    if (sh_halted) begin
      r = '{sh_cur_pc, sh_cur_pc, 1'b0, 5'd0, 32'd0, ST_HALTED};
      return r;
    end
    a = sh_regs[it.src_reg];
    b = sh_regs[it.tgt_reg];
    zimm = {16'd0, it.immediate};
    simm = {{16{it.immediate[15]}}, it.immediate};
    r.exec_pc = sh_cur_pc;
    sh_cur_pc = sh_nxt_pc;
    sh_nxt_pc = sh_cur_pc + 32'd4;
    base = sh_cur_pc;
    ea = a + simm;
    v = '0; widx = it.tgt_reg; wr = 0; st = ST_OK;
    m = word_at(ea);
    case (it.func)
      F_LB, F_LBU: begin
        m = m >> (8 * (3 - ea[1:0]));
        v = (it.func == F_LB) ? {{24{m[7]}}, m[7:0]} : {24'd0, m[7:0]};
        wr = 1;
      end
      F_LH, F_LHU: begin
        m = ea[1] ? m : (m >> 16);
        v = (it.func == F_LH) ? {{16{m[15]}}, m[15:0]} : {16'd0, m[15:0]};
        wr = 1;
      end
      F_LW: begin v = m; wr = 1; end
      F_LL: begin
        sh_link_ok = 1; sh_link_addr = ea; sh_link_old = m; v = m; wr = 1;
      end
      F_LWL: begin
        off = {1'b0, ea[1:0], 3'd0};
        v = (off == 0) ? m : ((m << off) | (b & ((32'd1 << off) - 32'd1)));
        wr = 1;
      end
      F_LWR: begin
        off = {1'b0, 2'd3 - ea[1:0], 3'd0};
        v = (off == 0) ? m : ((m >> off) | (b & (32'hFFFFFFFF << (32 - off))));
        wr = 1;
      end
      F_SB: begin
        off = {1'b0, 2'd3 - ea[1:0], 3'd0};
        merge_word(ea, {24'd0, b[7:0]} << off, 32'hFF << off);
      end
      F_SH: begin
        off = ea[1] ? 6'd0 : 6'd16;
        merge_word(ea, {16'd0, b[15:0]} << off, 32'hFFFF << off);
      end
      F_SW: merge_word(ea, b, 32'hFFFFFFFF);
      F_SC: begin
        // Drop the link if the linked word changed since ll.
        if (sh_link_ok && word_at(sh_link_addr) != sh_link_old) sh_link_ok = 0;
        if (sh_link_ok) merge_word(ea, b, 32'hFFFFFFFF);
        v = {31'd0, sh_link_ok}; wr = 1;
      end
      F_SWL: begin
        off = {1'b0, ea[1:0], 3'd0};
        merge_word(ea, b >> off, 32'hFFFFFFFF >> off);
      end
      F_SWR: begin
        off = {1'b0, 2'd3 - ea[1:0], 3'd0};
        merge_word(ea, b << off, 32'hFFFFFFFF << off);
      end
      F_ADDI: begin
        v = a + simm;
        if (would_trap(it)) st = ST_OVF; else wr = 1;
      end
      F_ADDIU: begin v = a + simm; wr = 1; end
      F_SLTI:  begin v = {31'd0, $signed(a) < $signed(simm)}; wr = 1; end
      F_SLTIU: begin v = {31'd0, a < simm}; wr = 1; end
      F_ANDI:  begin v = a & zimm; wr = 1; end
      F_ORI:   begin v = a | zimm; wr = 1; end
      F_XORI:  begin v = a ^ zimm; wr = 1; end
      F_LUI:   begin v = {it.immediate, 16'd0}; wr = 1; end
      default: begin
        widx = it.dst_reg;
        case (it.func)
          F_ADD: begin
            v = a + b;
            if (would_trap(it)) st = ST_OVF; else wr = 1;
          end
          F_ADDU: begin v = a + b; wr = 1; end
          F_SUB: begin
            v = a - b;
            if (would_trap(it)) st = ST_OVF; else wr = 1;
          end
          F_SUBU: begin v = a - b; wr = 1; end
          F_SLT:  begin v = {31'd0, $signed(a) < $signed(b)}; wr = 1; end
          F_SLTU: begin v = {31'd0, a < b}; wr = 1; end
          F_AND:  begin v = a & b; wr = 1; end
          F_OR:   begin v = a | b; wr = 1; end
          F_XOR:  begin v = a ^ b; wr = 1; end
          F_NOR:  begin v = ~(a | b); wr = 1; end
          F_SLL:  begin v = b << it.shift_amount; wr = 1; end
          F_SRL:  begin v = b >> it.shift_amount; wr = 1; end
          F_SRA:  begin v = $signed(b) >>> it.shift_amount; wr = 1; end
          F_SLLV: begin v = b << a[4:0]; wr = 1; end
          F_SRLV: begin v = b >> a[4:0]; wr = 1; end
          F_SRAV: begin v = $signed(b) >>> a[4:0]; wr = 1; end
          F_MULT: begin
            p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            sh_hi = p[63:32]; sh_lo = p[31:0];
          end
          F_MULTU: begin
            p = {32'd0, a} * {32'd0, b};
            sh_hi = p[63:32]; sh_lo = p[31:0];
          end
          F_DIV, F_DIVU: begin
            if (b == 0) begin
              sh_lo = 32'hFFFFFFFF; sh_hi = a;
            end else if (it.func == F_DIVU) begin
              sh_lo = a / b; sh_hi = a % b;
            end else begin
              // Divide magnitudes, then fix signs; covers the most negative by -1.
              na = a[31]; nb = b[31];
              ma = na ? -a : a; mb = nb ? -b : b;
              q = ma / mb; rm = ma % mb;
              sh_lo = (na != nb) ? -q : q;
              sh_hi = na ? -rm : rm;
            end
          end
          F_MFHI: begin v = sh_hi; wr = 1; end
          F_MTHI: sh_hi = a;
          F_MFLO: begin v = sh_lo; wr = 1; end
          F_MTLO: sh_lo = a;
          F_J: sh_nxt_pc = {base[31:28], it.jump_index, 2'b00};
          F_JAL: begin
            sh_nxt_pc = {base[31:28], it.jump_index, 2'b00};
            v = base + 32'd4; wr = 1; widx = 5'd31;
          end
          F_JR: sh_nxt_pc = a;
          F_JALR: begin
            sh_nxt_pc = a; v = base + 32'd4; wr = 1;
            widx = (it.dst_reg == 0) ? 5'd31 : it.dst_reg;
          end
          F_BEQ:  if (a == b) sh_nxt_pc = base + (simm << 2);
          F_BNE:  if (a != b) sh_nxt_pc = base + (simm << 2);
          F_BLEZ: if (a == 0 || a[31]) sh_nxt_pc = base + (simm << 2);
          F_BGTZ: if (!a[31] && a != 0) sh_nxt_pc = base + (simm << 2);
          F_BLTZ: if (a[31]) sh_nxt_pc = base + (simm << 2);
          F_BGEZ: if (!a[31]) sh_nxt_pc = base + (simm << 2);
          F_BLTZAL, F_BGEZAL: begin
            // Condition reads rs before r31 is written.
            if (a[31] == (it.func == F_BLTZAL)) sh_nxt_pc = base + (simm << 2);
            v = base + 32'd4; wr = 1; widx = 5'd31;
          end
          F_SYSCALL: st = ST_SYSCALL;
          F_BREAK:   st = ST_BREAK;
          default: ;
        endcase
      end
    endcase
    if (st != ST_OK) sh_halted = 1;
    if (wr && widx != 0) begin
      sh_regs[widx] = v;
    end else begin
      wr = 0; widx = 0; v = 0;
    end
    r.fetch_pc = sh_cur_pc;
    r.wrote_reg = wr;
    r.written_index = widx;
    r.written_value = v;
    r.status = st;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Result side: stall at random, mostly short.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || no_gaps) begin
      result.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Check every result word taken by the handshake.
  always @(posedge clk) begin
    retire_t got;
    if (!rst && result.valid && result.ready) begin
      got = '{result.exec_pc, result.fetch_pc, result.wrote_reg, result.written_index,
              result.written_value, result.status};
      ledger.check_retire(got);
    end
  end

  // Drive one word, wait for acceptance, predict, then idle or hold valid high.
  task automatic send_word(instr_word_t it);
    int gap;
    instr.valid        <= 1'b1;
    instr.func         <= it.func;
    instr.src_reg      <= it.src_reg;
    instr.tgt_reg      <= it.tgt_reg;
    instr.dst_reg      <= it.dst_reg;
    instr.shift_amount <= it.shift_amount;
    instr.immediate    <= it.immediate;
    instr.jump_index   <= it.jump_index;
    @(posedge clk);
    while (!instr.ready) @(posedge clk);
    ledger.note_retire(execute_instr(it));
    gap = pick_gap();
    if (gap > 0) begin
      instr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(logic [5:0] fn, logic [4:0] s, logic [4:0] t, logic [4:0] d,
                       logic [15:0] imm, logic [4:0] sa = 0, logic [25:0] ji = 0);
    instr_word_t it;
    it = '{fn, s, t, d, sa, imm, ji};
    send_word(it);
  endtask

  // Drain every owed result, then let the block idle.
  task automatic drain();
    instr.valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_start_pc(logic [31:0] pc);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sh_cur_pc = pc;
    sh_nxt_pc = pc + 32'd4;
  endtask

  // Random word: full-range noise, with most memory traffic kept in a small
  // window, and ll/sc pairs. Never halts.
  task automatic random_word(output instr_word_t it, inout bit sc_owed,
                             inout instr_word_t last_ll);
    it.func         = 6'($urandom_range(63));
    it.src_reg      = 5'($urandom_range(31));
    it.tgt_reg      = 5'($urandom_range(31));
    it.dst_reg      = 5'($urandom_range(31));
    it.shift_amount = 5'($urandom_range(31));
    it.immediate    = 16'($urandom_range(16'hFFFF));
    it.jump_index   = 26'($urandom_range(26'h3FFFFFF));
    if (sc_owed && $urandom_range(9) < 7) begin
      it.func = F_SC;
      it.src_reg = last_ll.src_reg;
      it.immediate = last_ll.immediate;
      sc_owed = 0;
    end else if (it.func <= F_SWR && $urandom_range(9) < 7) begin
      // Keep addresses in a small window so loads see earlier stores.
      it.src_reg = ($urandom_range(3) == 0) ? it.src_reg : 5'd0;
      if (it.src_reg == 0) it.immediate = 16'($urandom_range(255));
    end
    if (it.func == F_SYSCALL || it.func == F_BREAK) it.func = F_NOP;
    if (would_trap(it)) begin
      case (it.func)
        F_ADDI:  it.func = F_ADDIU;
        F_ADD:   it.func = F_ADDU;
        default: it.func = F_SUBU;
      endcase
    end
    if (it.func == F_LL) begin
      sc_owed = 1;
      last_ll = it;
    end
  endtask

  initial begin
    instr_word_t it, last_ll;
    bit          sc_owed;
    int          phase, halt_kind;
    instr.valid = 1'b0;
    instr.func = '0; instr.src_reg = '0; instr.tgt_reg = '0; instr.dst_reg = '0;
    instr.shift_amount = '0; instr.immediate = '0; instr.jump_index = '0;
    result.ready = 1'b1;
    foreach (sh_regs[i]) sh_regs[i] = '0;
    foreach (sh_mem[i]) sh_mem[i] = '0;
    sh_hi = '0; sh_lo = '0; sh_cur_pc = '0; sh_nxt_pc = 32'd4;
    sh_link_ok = 0; sh_link_addr = '0; sh_link_old = '0; sh_halted = 0;
    sc_owed = 0;
    last_ll = '{default: '0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: start next to the top of the address space so the PCs wrap.
    load_start_pc(32'hFFFFFFF8);
    issue(F_LUI,   0, 1, 0, 16'h8000);           // r1 = most negative
    issue(F_ADDIU, 0, 2, 0, 16'hFFFF);           // r2 = -1
    issue(F_ADDIU, 0, 0, 0, 16'h7FFF);           // write to r0 dropped
    issue(F_SRA,   0, 1, 3, 0, 5'd31);
    issue(F_ADDIU, 0, 6, 0, 16'd32);
    issue(F_SLLV,  6, 2, 5, 0);                  // shift by 32 masks to zero
    issue(F_DIV,   1, 2, 0, 0);                  // most negative by -1
    issue(F_MFLO,  0, 0, 7, 0);
    issue(F_DIVU,  2, 0, 0, 0);                  // divide by zero
    issue(F_MFHI,  0, 0, 8, 0);
    issue(F_MULT,  1, 2, 0, 0);
    issue(F_MFHI,  0, 0, 9, 0);
    issue(F_SW,    0, 2, 0, 16'd0);
    issue(F_SB,    0, 0, 0, 16'd1);
    issue(F_LWL,   0, 9, 0, 16'd1);
    issue(F_LWR,   0, 9, 0, 16'd2);
    issue(F_LB,    0, 10, 0, 16'd3);
    issue(F_LH,    0, 11, 0, 16'd2);
    issue(F_LL,    0, 12, 0, 16'd0);
    issue(F_SWR,   0, 1, 0, 16'd0);              // change the linked word
    issue(F_SC,    0, 13, 0, 16'd0);             // link broken: fails
    issue(F_LL,    0, 12, 0, 16'd4);
    issue(F_SC,    0, 2, 0, 16'd4);              // link holds: succeeds
    issue(F_JALR,  1, 0, 0, 0);                  // rd 0 links into r31
    issue(F_BLTZAL, 31, 0, 0, 16'h8000);
    issue(F_UNUSED, 31, 31, 31, 16'hFFFF, 5'd31, 26'h3FFFFFF);
    drain();

    // Random phases, each after a new start address.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_start_pc(32'd0);
        1: load_start_pc(32'hFFFFFFFF);
        2: load_start_pc($urandom);
        default: load_start_pc(32'hFFFFFFFC);
      endcase
      repeat (235) begin
        random_word(it, sc_owed, last_ll);
        send_word(it);
      end
      no_gaps = (phase == 2);
      drain();
    end
    no_gaps = 0;

    // Halt once, by overflow, syscall or break, then show items are ignored.
    halt_kind = $urandom_range(2);
    issue(F_LUI, 0, 1, 0, 16'h7FFF);
    issue(F_ORI, 1, 1, 0, 16'hFFFF);
    case (halt_kind)
      0: issue(F_ADD, 1, 1, 4, 0);
      1: issue(F_SYSCALL, 0, 0, 0, 0);
      default: issue(F_BREAK, 0, 0, 0, 0);
    endcase
    issue(F_ADDIU, 0, 5, 0, 16'd1);
    issue(F_SW, 0, 5, 0, 16'd0);
    issue(F_LW, 0, 6, 0, 16'd0);
    drain();

    if (ledger.owed.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, ledger.owed.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
